// ===== hw/rtl/lsvm_pkg.sv =====
package lsvm_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int WORD_W       = 32;
    localparam int INT_BITS     = WORD_W - FRAC_BITS;
    localparam int ANG_BITS     = 30;
    localparam int CORDIC_STEPS = ANG_BITS;
    localparam int T_W          = 50;
    localparam int NORM_POS     = 29;
    localparam int X_W          = T_W + NORM_POS;
    localparam int SC_W         = 30;
    localparam int SQ_W         = 2 * SC_W + 1;
    localparam int MANT_W       = 32;
    localparam int Y_W          = SQ_W + MANT_W - 1;
    localparam int EXP_W        = 6;
    localparam int LOG_W        = EXP_W + ANG_BITS;
    localparam int CX_W         = 34;
    localparam int CZ_W         = 33;
    localparam int TH_W         = 31;
    localparam int AT_W         = SC_W + TH_W;
    localparam int H_W          = 64;
    localparam int G_W          = 66;
    localparam int GD_W         = 63;
    localparam int PL_W         = 32 + ANG_BITS;
    localparam int PH_W         = GD_W - 32 + ANG_BITS;
    localparam int NUM_W        = 64;
    localparam int DEN_W        = T_W;
    localparam int DIV_STEPS    = WORD_W;
    localparam int NRM_STAGES   = 6;
    localparam int MSB_STAGES   = 6;
    localparam int LIM_SH       = 2 * ANG_BITS - FRAC_BITS;

    localparam logic [31:0]       PI4_Q30         = 32'd843314857;
    localparam logic [TH_W-1:0]   HALF_PI_Q30     = 31'd1686629713;
    localparam logic [29:0]       LN2_Q30         = 30'd744261118;
    localparam logic [29:0]       TWO_OVER_PI_Q30 = 30'd683565276;

    localparam logic [1:0] CFG_VANISH_X  = 2'd0;
    localparam logic [1:0] CFG_VANISH_Y  = 2'd1;
    localparam logic [1:0] CFG_VANISH_W  = 2'd2;
    localparam logic [1:0] CFG_THRESHOLD = 2'd3;

    typedef struct packed {
        logic signed [WORD_W-1:0] start_x;
        logic signed [WORD_W-1:0] start_y;
        logic signed [WORD_W-1:0] end_x;
        logic signed [WORD_W-1:0] end_y;
        logic signed [WORD_W-1:0] dir_x;
        logic signed [WORD_W-1:0] dir_y;
        logic signed [WORD_W-1:0] normal_a;
        logic signed [WORD_W-1:0] normal_b;
        logic signed [WORD_W-1:0] normal_c;
    } in_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] seg_length;
        logic [WORD_W-1:0] line_distance;
        logic [WORD_W-1:0] arrow_rate;
        logic              degenerate;
    } out_word_t;

    typedef logic [CORDIC_STEPS-1:0][31:0] atan_tab_t;

    // atan(2^-i) in Q30 from the power series in Q62
    function automatic atan_tab_t atan_table();
        atan_tab_t tab;
        logic signed [63:0] sum;
        logic [63:0] term;
        int p;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            sum = '0;
            for (int k = 0; k < 32; k++)
            begin
                p = i * (2 * k + 1);
                if (i != 0 && p <= 62)
                begin
                    term = (64'd1 << (62 - p)) / 64'(2 * k + 1);
                    if ((k & 1) != 0)
                        sum = sum - $signed(term);
                    else
                        sum = sum + $signed(term);
                end
            end
            if (i == 0)
                tab[i] = PI4_Q30;
            else
                tab[i] = 32'(($unsigned(sum) + (64'd1 << 31)) >> 32);
        end
        return tab;
    endfunction

    localparam atan_tab_t ATAN_TAB = atan_table();

endpackage

// ===== hw/rtl/line_segment_vanishing_metrics.sv =====
// Line segment metrics against a vanishing point.
// Input channel: item is taken at a rising edge with start high and busy low.
// busy stays low: the datapath is a fixed pipeline that takes one word per
// clock, back to back, with no bubbles needed between words.
// Output channel: done is high for one cycle with the result word on result;
// the receiver cannot stall, so nothing is ever held back.
// Throughput: one word per cycle.
// The depth is set by the two 30-step CORDIC chains running beside three
// 30-step log2 squaring chains (one 32x32 multiplier each per stage) and by
// the 32-step restoring divider at the end.
// Configuration: cfg_we writes cfg_data to register cfg_index (vanish_x,
// vanish_y, vanish_w, distance_threshold); write only while idle.
// Reset: rst_n clears the valid line and loads the register reset values;
// words in flight are dropped.
module line_segment_vanishing_metrics (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  lsvm_pkg::in_word_t    item,
    output logic                  done,
    output lsvm_pkg::out_word_t   result,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data
);
    import lsvm_pkg::*;

    localparam int DEPTH = 5 + (NRM_STAGES + 1) + 2 + (MSB_STAGES + 1)
                         + (CORDIC_STEPS + 1) + 7 + (DIV_STEPS + 1) + 1;

    localparam logic [1:0] RS_DIV = 2'd0;
    localparam logic [1:0] RS_LIM = 2'd1;
    localparam logic [1:0] RS_SAT = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] seg_length;
        logic [WORD_W-1:0] line_distance;
        logic              degen;
        logic              arc;
        logic [T_W-1:0]    near_num;
        logic [T_W-1:0]    dt;
    } carry_t;

    typedef struct packed {
        logic [T_W-1:0]          m;
        logic [2:0][X_W-1:0]     x;
        logic                    t1neg;
        logic                    t2neg;
        carry_t                  c;
    } nrm_t;

    typedef struct packed {
        logic [SC_W-1:0] s1;
        logic [SC_W-1:0] s2;
        logic [SC_W-1:0] d;
        logic [SC_W:0]   adp;
        logic            dpz;
        carry_t          c;
    } sc_t;

    typedef struct packed {
        logic [2:0][Y_W-1:0]   y;
        logic [2:0][EXP_W-1:0] e;
        sc_t                   sc;
    } msb_t;

    typedef struct packed {
        logic [2:0][MANT_W-1:0] mant;
        logic [2:0][LOG_W-1:0]  lg;
        logic [1:0][CX_W-1:0]   cx;
        logic [1:0][CX_W-1:0]   cy;
        logic [1:0][CZ_W-1:0]   cz;
        sc_t                    sc;
    } sq_t;

    typedef struct packed {
        logic [1:0][TH_W-1:0]  th;
        logic [1:0][LOG_W-1:0] l2;
        logic [1:0][LOG_W-1:0] lnq;
        logic [1:0][AT_W-1:0]  at;
        logic [1:0][H_W-1:0]   h;
        logic [1:0][G_W-1:0]   g;
        logic [GD_W-1:0]       gd;
        logic [PL_W-1:0]       pl;
        logic [PH_W-1:0]       ph;
        logic [NUM_W-1:0]      num;
        logic [WORD_W-1:0]     lim;
        sc_t                   sc;
    } dp_t;

    typedef struct packed {
        logic [DEN_W-1:0]  rem;
        logic [DEN_W-1:0]  den;
        logic [WORD_W-1:0] sh;
        logic [WORD_W-1:0] q;
        logic [1:0]        sel;
        logic [WORD_W-1:0] lim;
        carry_t            c;
    } div_t;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic [T_W-1:0] mag_t(input logic signed [T_W-1:0] v);
        return v[T_W-1] ? T_W'(-v) : T_W'(v);
    endfunction

    function automatic logic [WORD_W-1:0] sat32(input logic [T_W-1:0] v);
        return (|v[T_W-1:WORD_W]) ? '1 : v[WORD_W-1:0];
    endfunction

    // configuration
    logic signed [WORD_W-1:0] vx_reg, vy_reg, vw_reg;
    logic [WORD_W-2:0]        thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vx_reg  <= '0;
            vy_reg  <= '0;
            vw_reg  <= 32'sd65536;
            thr_reg <= 31'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VANISH_X:  vx_reg  <= cfg_data;
                CFG_VANISH_Y:  vy_reg  <= cfg_data;
                CFG_VANISH_W:  vw_reg  <= cfg_data;
                CFG_THRESHOLD: thr_reg <= cfg_data[WORD_W-2:0];
            endcase
        end
    end

    logic [DEPTH-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[DEPTH-2:0], start & ~busy};
    end

    assign busy = 1'b0;
    assign done = vld_reg[DEPTH-1];

    // front end: offsets, products, rounding, sums
    logic signed [32:0]       opa_reg [7];
    logic signed [WORD_W-1:0] opb_reg [7];
    logic [63:0]              pm_reg [7];
    logic                     pneg_reg [7];
    logic signed [T_W-1:0]    fr_reg [7];
    logic signed [T_W-1:0]    t1_reg, t2_reg, dsum_reg;
    logic [T_W-1:0]           a1_reg, a2_reg, ds_reg, dt_reg;
    logic                     t1neg_reg, t2neg_reg, degen_reg;

    always_ff @(posedge clk)
    begin
        opa_reg[0] <= 33'(item.start_x) - 33'(vx_reg);
        opa_reg[1] <= 33'(item.start_y) - 33'(vy_reg);
        opa_reg[2] <= 33'(item.end_x) - 33'(vx_reg);
        opa_reg[3] <= 33'(item.end_y) - 33'(vy_reg);
        opa_reg[4] <= 33'(vx_reg);
        opa_reg[5] <= 33'(vy_reg);
        opa_reg[6] <= 33'(vw_reg);
        opb_reg[0] <= item.dir_x;
        opb_reg[1] <= item.dir_y;
        opb_reg[2] <= item.dir_x;
        opb_reg[3] <= item.dir_y;
        opb_reg[4] <= item.normal_a;
        opb_reg[5] <= item.normal_b;
        opb_reg[6] <= item.normal_c;
        for (int k = 0; k < 7; k++)
        begin
            pm_reg[k]   <= 64'(mag33(opa_reg[k])) * 64'(mag33(33'(opb_reg[k])));
            pneg_reg[k] <= opa_reg[k][32] ^ opb_reg[k][WORD_W-1];
            fr_reg[k]   <= pneg_reg[k]
                ? -$signed(T_W'((pm_reg[k] + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS))
                :  $signed(T_W'((pm_reg[k] + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS));
        end
        t1_reg    <= fr_reg[0] + fr_reg[1];
        t2_reg    <= fr_reg[2] + fr_reg[3];
        dsum_reg  <= fr_reg[4] + fr_reg[5] + fr_reg[6];
        a1_reg    <= mag_t(t1_reg);
        a2_reg    <= mag_t(t2_reg);
        ds_reg    <= mag_t(dsum_reg);
        dt_reg    <= T_W'(mag_t(T_W'((T_W + 1)'(t1_reg) - (T_W + 1)'(t2_reg))));
        t1neg_reg <= t1_reg[T_W-1];
        t2neg_reg <= t2_reg[T_W-1];
        degen_reg <= (t1_reg == t2_reg);
    end

    // common scaling so the largest magnitude lands in [2^29, 2^30)
    nrm_t nrm_reg [NRM_STAGES+1];
    nrm_t nrm_load;

    always_comb
    begin
        logic [T_W-1:0] mx;
        mx = (a1_reg > a2_reg) ? a1_reg : a2_reg;
        mx = (ds_reg > mx) ? ds_reg : mx;
        nrm_load.m     = mx;
        nrm_load.x[0]  = {a1_reg, {NORM_POS{1'b0}}};
        nrm_load.x[1]  = {a2_reg, {NORM_POS{1'b0}}};
        nrm_load.x[2]  = {ds_reg, {NORM_POS{1'b0}}};
        nrm_load.t1neg = t1neg_reg;
        nrm_load.t2neg = t2neg_reg;
        nrm_load.c.seg_length    = sat32(dt_reg);
        nrm_load.c.line_distance = sat32(ds_reg);
        nrm_load.c.degen         = degen_reg;
        nrm_load.c.arc           = ds_reg > T_W'(thr_reg);
        nrm_load.c.near_num      = (a1_reg > a2_reg) ? a1_reg - a2_reg : a2_reg - a1_reg;
        nrm_load.c.dt            = dt_reg;
    end

    always_ff @(posedge clk)
        nrm_reg[0] <= nrm_load;

    for (genvar j = 0; j < NRM_STAGES; j++)
    begin : g_nrm
        localparam int SH = 1 << (NRM_STAGES - 1 - j);
        nrm_t nxt;
        always_comb
        begin
            nxt = nrm_reg[j];
            if ((nrm_reg[j].m >> SH) != '0)
            begin
                nxt.m = nrm_reg[j].m >> SH;
                for (int k = 0; k < 3; k++)
                    nxt.x[k] = nrm_reg[j].x[k] >> SH;
            end
        end
        always_ff @(posedge clk)
            nrm_reg[j+1] <= nxt;
    end

    // scaled operands and squares
    sc_t                    c1_reg, c2_reg;
    logic [2:0][2*SC_W-1:0] sqr_reg;
    sc_t                    c1_next;

    always_comb
    begin
        logic signed [SC_W:0]   p1, p2;
        logic signed [SC_W+1:0] dp;
        c1_next.s1 = nrm_reg[NRM_STAGES].x[0][SC_W-1:0];
        c1_next.s2 = nrm_reg[NRM_STAGES].x[1][SC_W-1:0];
        c1_next.d  = (nrm_reg[NRM_STAGES].x[2][SC_W-1:0] == '0)
                   ? SC_W'(1) : nrm_reg[NRM_STAGES].x[2][SC_W-1:0];
        p1 = nrm_reg[NRM_STAGES].t1neg ? -$signed({1'b0, c1_next.s1})
                                       :  $signed({1'b0, c1_next.s1});
        p2 = nrm_reg[NRM_STAGES].t2neg ? -$signed({1'b0, c1_next.s2})
                                       :  $signed({1'b0, c1_next.s2});
        dp = (SC_W + 2)'(p1) - (SC_W + 2)'(p2);
        c1_next.adp = dp[SC_W+1] ? (SC_W + 1)'(-dp) : (SC_W + 1)'(dp);
        c1_next.dpz = (dp == '0);
        c1_next.c   = nrm_reg[NRM_STAGES].c;
    end

    always_ff @(posedge clk)
    begin
        c1_reg     <= c1_next;
        c2_reg     <= c1_reg;
        sqr_reg[0] <= (2 * SC_W)'(c1_reg.d) * (2 * SC_W)'(c1_reg.d);
        sqr_reg[1] <= (2 * SC_W)'(c1_reg.s1) * (2 * SC_W)'(c1_reg.s1);
        sqr_reg[2] <= (2 * SC_W)'(c1_reg.s2) * (2 * SC_W)'(c1_reg.s2);
    end

    // leading one search for the log2 arguments: d^2, d^2+s1^2, d^2+s2^2
    msb_t msb_reg [MSB_STAGES+1];
    msb_t msb_load;

    always_comb
    begin
        msb_load.y[0] = {SQ_W'(sqr_reg[0]), {(MANT_W - 1){1'b0}}};
        msb_load.y[1] = {SQ_W'(sqr_reg[0]) + SQ_W'(sqr_reg[1]), {(MANT_W - 1){1'b0}}};
        msb_load.y[2] = {SQ_W'(sqr_reg[0]) + SQ_W'(sqr_reg[2]), {(MANT_W - 1){1'b0}}};
        msb_load.e    = '0;
        msb_load.sc   = c2_reg;
    end

    always_ff @(posedge clk)
        msb_reg[0] <= msb_load;

    for (genvar j = 0; j < MSB_STAGES; j++)
    begin : g_msb
        localparam int SH = 1 << (MSB_STAGES - 1 - j);
        msb_t nxt;
        always_comb
        begin
            nxt = msb_reg[j];
            for (int k = 0; k < 3; k++)
            begin
                if ((msb_reg[j].y[k] >> (MANT_W - 1 + SH)) != '0)
                begin
                    nxt.y[k] = msb_reg[j].y[k] >> SH;
                    nxt.e[k] = msb_reg[j].e[k] + EXP_W'(SH);
                end
            end
        end
        always_ff @(posedge clk)
            msb_reg[j+1] <= nxt;
    end

    // log2 squaring steps beside the two CORDIC chains
    sq_t sq_reg [CORDIC_STEPS+1];
    sq_t sq_load;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq_load.mant[k] = msb_reg[MSB_STAGES].y[k][MANT_W-1:0];
            sq_load.lg[k]   = {msb_reg[MSB_STAGES].e[k], {ANG_BITS{1'b0}}};
        end
        sq_load.cx[0] = CX_W'(msb_reg[MSB_STAGES].sc.d);
        sq_load.cx[1] = CX_W'(msb_reg[MSB_STAGES].sc.d);
        sq_load.cy[0] = CX_W'(msb_reg[MSB_STAGES].sc.s1);
        sq_load.cy[1] = CX_W'(msb_reg[MSB_STAGES].sc.s2);
        sq_load.cz    = '0;
        sq_load.sc    = msb_reg[MSB_STAGES].sc;
    end

    always_ff @(posedge clk)
        sq_reg[0] <= sq_load;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_sq
        localparam int B = ANG_BITS - 1 - i;
        sq_t nxt;
        always_comb
        begin
            logic [2*MANT_W-1:0]     sqv;
            logic [MANT_W:0]         tv;
            logic signed [CX_W-1:0]  x, y;
            logic signed [CZ_W-1:0]  z, at;
            nxt = sq_reg[i];
            for (int k = 0; k < 3; k++)
            begin
                sqv = (2 * MANT_W)'(sq_reg[i].mant[k]) * (2 * MANT_W)'(sq_reg[i].mant[k]);
                tv  = (MANT_W + 1)'(sqv >> (MANT_W - 1));
                if (tv[MANT_W])
                begin
                    nxt.mant[k]  = tv[MANT_W:1];
                    nxt.lg[k][B] = 1'b1;
                end
                else
                    nxt.mant[k] = tv[MANT_W-1:0];
            end
            at = $signed({1'b0, ATAN_TAB[i]});
            for (int l = 0; l < 2; l++)
            begin
                x = $signed(sq_reg[i].cx[l]);
                y = $signed(sq_reg[i].cy[l]);
                z = $signed(sq_reg[i].cz[l]);
                if (y != '0)
                begin
                    if (!y[CX_W-1])
                    begin
                        nxt.cx[l] = x + (y >>> i);
                        nxt.cy[l] = y - (x >>> i);
                        nxt.cz[l] = z + at;
                    end
                    else
                    begin
                        nxt.cx[l] = x + ((-y) >>> i);
                        nxt.cy[l] = y + (x >>> i);
                        nxt.cz[l] = z - at;
                    end
                end
            end
        end
        always_ff @(posedge clk)
            sq_reg[i+1] <= nxt;
    end

    // g(a) = a*atan(a/d) - (d/2) ln(1 + (a/d)^2), difference, 2/pi scaling
    dp_t d_reg [1:7];
    dp_t d_next [1:7];

    always_comb
    begin
        logic signed [CZ_W-1:0] z;
        d_next[1]    = '0;
        d_next[1].sc = sq_reg[CORDIC_STEPS].sc;
        for (int l = 0; l < 2; l++)
        begin
            z = $signed(sq_reg[CORDIC_STEPS].cz[l]);
            if (z[CZ_W-1])
                d_next[1].th[l] = '0;
            else if (z > $signed({2'b0, HALF_PI_Q30}))
                d_next[1].th[l] = HALF_PI_Q30;
            else
                d_next[1].th[l] = TH_W'(z);
            d_next[1].l2[l] = (sq_reg[CORDIC_STEPS].lg[l+1] > sq_reg[CORDIC_STEPS].lg[0])
                ? sq_reg[CORDIC_STEPS].lg[l+1] - sq_reg[CORDIC_STEPS].lg[0] : '0;
        end
    end

    always_comb
    begin
        logic [2*ANG_BITS+6:0] lp;
        logic [TH_W+29:0]      lm;
        d_next[2] = d_reg[1];
        for (int l = 0; l < 2; l++)
        begin
            lp = (2 * ANG_BITS + 7)'(d_reg[1].l2[l]) * (2 * ANG_BITS + 7)'(LN2_Q30);
            d_next[2].lnq[l] = LOG_W'(lp >> ANG_BITS);
        end
        d_next[2].at[0] = AT_W'(d_reg[1].sc.s1) * AT_W'(d_reg[1].th[0]);
        d_next[2].at[1] = AT_W'(d_reg[1].sc.s2) * AT_W'(d_reg[1].th[1]);
        lm = (TH_W + 30)'(d_reg[1].th[0]) * (TH_W + 30)'(TWO_OVER_PI_Q30);
        d_next[2].lim = WORD_W'(lm >> LIM_SH);
    end

    always_comb
    begin
        logic [SC_W+LOG_W-1:0] hp;
        d_next[3] = d_reg[2];
        for (int l = 0; l < 2; l++)
        begin
            hp = (SC_W + LOG_W)'(d_reg[2].sc.d) * (SC_W + LOG_W)'(d_reg[2].lnq[l]);
            d_next[3].h[l] = H_W'(hp >> 1);
        end
    end

    always_comb
    begin
        d_next[4] = d_reg[3];
        for (int l = 0; l < 2; l++)
            d_next[4].g[l] = G_W'($signed({1'b0, d_reg[3].at[l]})
                                - $signed({1'b0, d_reg[3].h[l]}));
    end

    always_comb
    begin
        logic signed [G_W-1:0] gdf;
        d_next[5] = d_reg[4];
        gdf = $signed(d_reg[4].g[0]) - $signed(d_reg[4].g[1]);
        d_next[5].gd = gdf[G_W-1] ? GD_W'(-gdf) : GD_W'(gdf);
    end

    always_comb
    begin
        d_next[6]    = d_reg[5];
        d_next[6].pl = PL_W'(d_reg[5].gd[31:0]) * PL_W'(TWO_OVER_PI_Q30);
        d_next[6].ph = PH_W'(d_reg[5].gd[GD_W-1:32]) * PH_W'(TWO_OVER_PI_Q30);
    end

    always_comb
    begin
        logic [PH_W+32:0] acc;
        d_next[7] = d_reg[6];
        acc = (PH_W + 33)'(d_reg[6].pl) + ((PH_W + 33)'(d_reg[6].ph) << 32);
        d_next[7].num = NUM_W'(acc >> ANG_BITS);
    end

    always_ff @(posedge clk)
        for (int k = 1; k <= 7; k++)
            d_reg[k] <= (k == 1) ? d_next[1] : d_next[k];

    // restoring divider, one quotient bit per stage
    div_t div_reg [DIV_STEPS+1];
    div_t div_load;

    always_comb
    begin
        logic [NUM_W-1:0] nn;
        logic [NUM_W-1:0] hi;
        logic             ovf;
        if (d_reg[7].sc.c.arc)
        begin
            nn           = d_reg[7].num;
            div_load.den = DEN_W'({d_reg[7].sc.adp, {(ANG_BITS - FRAC_BITS){1'b0}}});
        end
        else
        begin
            nn           = NUM_W'(d_reg[7].sc.c.near_num);
            div_load.den = d_reg[7].sc.c.dt;
        end
        hi  = nn >> INT_BITS;
        ovf = hi >= NUM_W'(div_load.den);
        div_load.rem = DEN_W'(hi);
        div_load.sh  = {nn[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
        div_load.q   = '0;
        div_load.lim = d_reg[7].lim;
        div_load.c   = d_reg[7].sc.c;
        priority if (d_reg[7].sc.c.degen)
            div_load.sel = RS_SAT;
        else if (d_reg[7].sc.c.arc && d_reg[7].sc.dpz)
            div_load.sel = RS_LIM;
        else if (ovf)
            div_load.sel = RS_SAT;
        else
            div_load.sel = RS_DIV;
    end

    always_ff @(posedge clk)
        div_reg[0] <= div_load;

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        div_t nxt;
        always_comb
        begin
            logic [DEN_W:0] r2;
            nxt = div_reg[j];
            r2  = {div_reg[j].rem, div_reg[j].sh[WORD_W-1]};
            nxt.sh = div_reg[j].sh << 1;
            if (r2 >= {1'b0, div_reg[j].den})
            begin
                nxt.rem = DEN_W'(r2 - {1'b0, div_reg[j].den});
                nxt.q   = {div_reg[j].q[WORD_W-2:0], 1'b1};
            end
            else
            begin
                nxt.rem = r2[DEN_W-1:0];
                nxt.q   = {div_reg[j].q[WORD_W-2:0], 1'b0};
            end
        end
        always_ff @(posedge clk)
            div_reg[j+1] <= nxt;
    end

    // output word
    out_word_t result_reg, result_next;

    always_comb
    begin
        result_next.seg_length    = div_reg[DIV_STEPS].c.seg_length;
        result_next.line_distance = div_reg[DIV_STEPS].c.line_distance;
        result_next.degenerate    = div_reg[DIV_STEPS].c.degen;
        case (div_reg[DIV_STEPS].sel)
            RS_DIV:  result_next.arrow_rate = div_reg[DIV_STEPS].q;
            RS_LIM:  result_next.arrow_rate = div_reg[DIV_STEPS].lim;
            default: result_next.arrow_rate = '1;
        endcase
    end

    always_ff @(posedge clk)
        result_reg <= result_next;

    assign result = result_reg;

endmodule

// ===== dv/lsvm_checker.sv =====
`timescale 1ns / 1ps

module lsvm_checker
    import lsvm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  in_word_t    item,
    input  logic        done,
    input  out_word_t   result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          checked
);

    localparam logic [63:0] SAT = 64'hFFFFFFFF;
    localparam logic [63:0] K_LN2 = 64'd744261118;
    localparam logic [63:0] K_2PI = 64'd683565276;
    localparam logic signed [63:0] K_HPI = 64'sd1686629713;

    logic signed [63:0] vp_x, vp_y, vp_w;
    logic [63:0]        dist_thr;
    out_word_t          metrics_q[$];

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        if (v < 0)
            return -v;
        return v;
    endfunction

    function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic [63:0] m, r;
        m = abs64(a) * abs64(b);
        r = (m + 64'd32768) >> 16;
        if ((a < 0) != (b < 0))
            return -$signed(r);
        return $signed(r);
    endfunction

    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                              input int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> s;
        if (p[127:64] != 0)
            return '1;
        return p[63:0];
    endfunction

    function automatic logic [63:0] frac_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q, r;
        q = num / den;
        r = num % den;
        if (q > (SAT >> 16))
            return SAT;
        for (int i = 0; i < 16; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic signed [63:0] atan_step(input int i);
        logic signed [63:0] sum;
        logic [63:0] term;
        int p;
        if (i == 0)
            return 64'sd843314857;
        sum = 0;
        for (int k = 0; ; k++)
        begin
            p = i * (2 * k + 1);
            if (p > 62)
                break;
            term = (64'd1 << (62 - p)) / 64'(2 * k + 1);
            if (k & 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        return $signed(($unsigned(sum) + (64'd1 << 31)) >> 32);
    endfunction

    function automatic logic [63:0] angle_of(input logic [63:0] x0, input logic [63:0] y0);
        logic signed [63:0] x, y, z, nx, at;
        x = $signed(x0);
        y = $signed(y0);
        z = 0;
        for (int i = 0; i < 30; i++)
        begin
            if (y == 0)
                break;
            at = atan_step(i);
            if (y > 0)
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + at;
            end
            else
            begin
                nx = x + ((-y) >>> i);
                y = y + (x >>> i);
                z = z - at;
            end
            x = nx;
        end
        if (z < 0)
            z = 0;
        if (z > K_HPI)
            z = K_HPI;
        return z;
    endfunction

    function automatic logic [63:0] log2_q30(input logic [63:0] n);
        int e;
        logic [63:0] m, r;
        e = 0;
        while (e < 63 && (n >> (e + 1)) != 0)
            e++;
        m = (e >= 31) ? n >> (e - 31) : n << (31 - e);
        r = 64'(e) << 30;
        for (int b = 29; b >= 0; b--)
        begin
            m = (m * m) >> 31;
            if (m >> 32)
            begin
                m = m >> 1;
                r[b] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic signed [63:0] g_term(input logic [63:0] d, input logic [63:0] a,
                                                  input logic [63:0] th);
        logic [63:0] hi, lo, l2, lnq, h;
        hi = log2_q30(d * d + a * a);
        lo = log2_q30(d * d);
        l2 = (hi > lo) ? hi - lo : 0;
        lnq = mul_shift(l2, K_LN2, 30);
        h = mul_shift(d, lnq, 1);
        return $signed(a * th) - $signed(h);
    endfunction

    function automatic logic [63:0] arc_metric(input logic signed [63:0] t1,
                                               input logic signed [63:0] t2,
                                               input logic [63:0] ds);
        logic [63:0] a1, a2, m, s1, s2, d, th1, th2, num;
        logic signed [63:0] p1, p2, dp, g1, g2;
        int r, l;
        a1 = abs64(t1);
        a2 = abs64(t2);
        m = ds;
        r = 0;
        l = 0;
        if (a1 > m)
            m = a1;
        if (a2 > m)
            m = a2;
        while ((m >> r) >= 64'h40000000)
            r++;
        if (r == 0)
            while ((m << l) < 64'h20000000)
                l++;
        s1 = r ? a1 >> r : a1 << l;
        s2 = r ? a2 >> r : a2 << l;
        d = r ? ds >> r : ds << l;
        if (d == 0)
            d = 1;
        p1 = (t1 < 0) ? -$signed(s1) : $signed(s1);
        p2 = (t2 < 0) ? -$signed(s2) : $signed(s2);
        dp = p1 - p2;
        th1 = angle_of(d, s1);
        if (dp == 0)
            return mul_shift(th1, K_2PI, 30) >> 14;
        th2 = angle_of(d, s2);
        g1 = g_term(d, s1, th1);
        g2 = g_term(d, s2, th2);
        num = mul_shift(abs64(g1 - g2), K_2PI, 30);
        return frac_div(num, abs64(dp) << 14);
    endfunction

    function automatic out_word_t segment_metrics(input in_word_t w);
        logic signed [63:0] sx, sy, ex, ey, dx, dy, na, nb, nc, t1, t2, dsum;
        logic [63:0] ds, a1, a2, dt, rate;
        out_word_t o;
        sx = w.start_x; sy = w.start_y; ex = w.end_x; ey = w.end_y;
        dx = w.dir_x; dy = w.dir_y; na = w.normal_a; nb = w.normal_b; nc = w.normal_c;
        t1 = qmul(sx - vp_x, dx) + qmul(sy - vp_y, dy);
        t2 = qmul(ex - vp_x, dx) + qmul(ey - vp_y, dy);
        dsum = qmul(vp_x, na) + qmul(vp_y, nb) + qmul(vp_w, nc);
        ds = abs64(dsum);
        a1 = abs64(t1);
        a2 = abs64(t2);
        dt = abs64(t1 - t2);
        o.degenerate = 1'b0;
        if (t1 == t2)
        begin
            rate = SAT;
            o.degenerate = 1'b1;
        end
        else if (ds > dist_thr)
            rate = arc_metric(t1, t2, ds);
        else
            rate = frac_div((a1 > a2) ? a1 - a2 : a2 - a1, dt);
        o.seg_length = (dt > SAT) ? SAT[31:0] : dt[31:0];
        o.line_distance = (ds > SAT) ? SAT[31:0] : ds[31:0];
        o.arrow_rate = (rate > SAT) ? SAT[31:0] : rate[31:0];
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t e;
        if (!rst_n)
        begin
            vp_x <= 0;
            vp_y <= 0;
            vp_w <= 65536;
            dist_thr <= 1;
            metrics_q.delete();
            errors <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_VANISH_X:  vp_x <= $signed(cfg_data);
                    CFG_VANISH_Y:  vp_y <= $signed(cfg_data);
                    CFG_VANISH_W:  vp_w <= $signed(cfg_data);
                    CFG_THRESHOLD: dist_thr <= {33'd0, cfg_data[30:0]};
                    default: ;
                endcase
            end
            if (start && !busy)
                metrics_q.push_back(segment_metrics(item));
            if (done)
            begin
                if (metrics_q.size() == 0)
                begin
                    $display("%0t: unexpected word %h", $time, result);
                    errors <= errors + 1;
                end
                else
                begin
                    e = metrics_q.pop_front();
                    checked <= checked + 1;
                    if (result.seg_length !== e.seg_length
                        || result.line_distance !== e.line_distance
                        || result.arrow_rate !== e.arrow_rate
                        || result.degenerate !== e.degenerate)
                    begin
                        $display("%0t: mismatch exp len %h dist %h rate %h deg %b",
                                 $time, e.seg_length, e.line_distance, e.arrow_rate,
                                 e.degenerate);
                        $display("%0t:          got len %h dist %h rate %h deg %b",
                                 $time, result.seg_length, result.line_distance,
                                 result.arrow_rate, result.degenerate);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= metrics_q.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import lsvm_pkg::*;

    localparam int LIMIT = 200000;
    localparam int PHASES = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    in_word_t    item = '0;
    logic        busy, done;
    out_word_t   result;
    int          errors, pending, checked;
    int          cyc = 0;
    bit          gaps_on = 1'b1;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    line_segment_vanishing_metrics u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    lsvm_checker u_chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .errors(errors), .pending(pending), .checked(checked)
    );

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] rnd_val(input int kind);
        case (kind)
            0: return $urandom;
            1: return 32'($urandom_range(0, 2 ** 21)) - 32'h0010_0000;
            default:
                case ($urandom_range(4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
        endcase
    endfunction

    function automatic in_word_t rnd_segment();
        in_word_t w;
        int style, kind;
        style = $urandom_range(9);
        kind = (style < 2) ? 0 : (style == 8) ? 2 : 1;
        w.start_x = rnd_val(kind);
        w.start_y = rnd_val(kind);
        w.end_x = rnd_val(kind);
        w.end_y = rnd_val(kind);
        w.dir_x = rnd_val(kind);
        w.dir_y = rnd_val(kind);
        w.normal_a = rnd_val(kind);
        w.normal_b = rnd_val(kind);
        w.normal_c = rnd_val(kind);
        if (style == 9)
        begin
            w.end_x = w.start_x;
            w.end_y = w.start_y;
        end
        return w;
    endfunction

    task automatic send(input in_word_t w);
        logic b;
        item <= w;
        start <= 1'b1;
        forever
        begin
            @(negedge clk);
            b = busy;
            @(posedge clk);
            if (!b)
                break;
        end
        if (gaps_on && $urandom_range(99) < 13)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic set_vanish(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] w, input logic [31:0] thr);
        write_reg(CFG_VANISH_X, x);
        write_reg(CFG_VANISH_Y, y);
        write_reg(CFG_VANISH_W, w);
        write_reg(CFG_THRESHOLD, thr);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_fields(input logic [31:0] sx, input logic [31:0] sy,
                               input logic [31:0] ex, input logic [31:0] ey,
                               input logic [31:0] dx, input logic [31:0] dy,
                               input logic [31:0] na, input logic [31:0] nb,
                               input logic [31:0] nc);
        send({sx, sy, ex, ey, dx, dy, na, nb, nc});
    endtask

    initial
    begin
        in_word_t w;
        int n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_vanish(32'd0, 32'd0, 32'd65536, 32'd1);
        send('0);
        send('1);
        send({9{32'h8000_0000}});
        send({9{32'h7FFF_FFFF}});
        send_fields(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000,
                    32'h0001_0000, 32'h0000_8000, 0, 0, 32'h0004_0000);
        send_fields(32'h0001_0000, 32'h0002_0000, 32'h0005_0000, 32'h0007_0000,
                    0, 0, 0, 0, 32'h0004_0000);
        send_fields(32'h0001_0000, 32'h0000_0000, 32'h0004_0000, 32'h0000_0000,
                    32'h0001_0000, 0, 0, 0, 0);
        send_fields(32'hFFFD_0000, 32'h0000_0000, 32'h0004_0000, 32'h0000_0000,
                    32'h0001_0000, 0, 0, 0, 0);
        send_fields(32'h0001_0000, 32'h0000_0000, 32'h0004_0000, 32'h0000_0000,
                    32'h0001_0000, 0, 0, 0, 32'h0003_0000);
        send_fields(32'hFFFD_0000, 32'h0001_0000, 32'h0004_0000, 32'hFFFF_0000,
                    32'h0000_8000, 32'hFFFF_8000, 0, 0, 32'hFFF0_0000);
        // huge ends one step apart: rescaled values collapse
        send_fields(32'h7FFF_0000, 0, 32'h7FFE_FFFF, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h0001_0000);
        // tiny distance against huge ends: rescaled distance becomes zero
        send_fields(32'h7FFF_0000, 0, 32'h1000_0000, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'd2);
        send_fields(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h8000_0000);
        send_fields(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
                    32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1);
        send_fields(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                    32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                    32'h5555_5555);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: set_vanish(32'd0, 32'd0, 32'd65536, 32'd1);
                1: set_vanish(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
                2: set_vanish(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
                3: set_vanish($urandom_range(0, 2 ** 21) - 32'h0010_0000,
                              $urandom_range(0, 2 ** 21) - 32'h0010_0000,
                              32'h0001_0000, 32'h8000_0000 | $urandom_range(0, 2 ** 22));
                4: set_vanish($urandom, $urandom, $urandom, $urandom);
                default: set_vanish(32'h0003_0000, 32'hFFFE_0000, 32'hFFFF_0000,
                                    32'h0010_0000);
            endcase
            n = (ph == 0) ? 195 : 190;
            gaps_on = (ph != 2);
            for (int i = 0; i < n; i++)
            begin
                w = rnd_segment();
                send(w);
                if (ph == 3 && i == 90)
                    drain();
            end
            drain();
        end

        $display("Checked %0d segment words over %0d vanishing point settings,",
                 checked, PHASES + 1);
        $display("covering both rate branches, degenerate and extreme segments.");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
